// ----- hdl/bitp_pkg.sv -----
// Shared types, codes and the character decode for the bounded integer text parser.
package bitp_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RADIX_MODE  = 2'd0;
   localparam logic [1:0] CSR_SIGNED_MODE = 2'd1;
   localparam logic [1:0] CSR_UPPER_LIMIT = 2'd2;
   localparam logic [1:0] CSR_LOWER_LIMIT = 2'd3;

   // Radix codes; the unused code behaves as decimal.
   localparam logic [1:0] RADIX_DEC    = 2'd0;
   localparam logic [1:0] RADIX_HEX    = 2'd1;
   localparam logic [1:0] RADIX_OCT    = 2'd2;
   localparam logic [1:0] RADIX_UNUSED = 2'd3;

   // Characters of interest.
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   localparam logic [63:0] INT64_MAX_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [15:0] CONSUMED_MAX    = 16'hFFFF;

   // Parse phase, one-hot.
   typedef enum logic [2:0] {
      PH_START   = 3'b001,
      PH_DIGITS  = 3'b010,
      PH_STOPPED = 3'b100
   } phase_type;

   // Decoded digit: ok is low for a character that is not a digit of the radix.
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   // Decode one character as a digit of the selected radix.
   function automatic digit_type digit_decode(logic [7:0] c, logic [1:0] radix);
      digit_type  d;
      logic [7:0] diff;
      logic       is_num;
      logic       is_lower;
      logic       is_upper;
      is_num   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_lower = (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F);
      is_upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F);
      if (is_num) begin
         diff = c - CHAR_ZERO;
      end else if (is_lower) begin
         diff = c - CHAR_LOWER_A + 8'd10;
      end else begin
         diff = c - CHAR_UPPER_A + 8'd10;
      end
      d.val = diff[3:0];
      unique case (radix)
         RADIX_HEX: d.ok = is_num || is_lower || is_upper;
         RADIX_OCT: d.ok = is_num && (d.val < 4'd8);
         default:   d.ok = is_num;
      endcase
      return d;
   endfunction

endpackage

// ----- hdl/bounded_integer_text_parser.sv -----
// Bounded integer text parser: one character per transaction, one result per string.
//
// The req channel carries one character of a string per transaction, with
// req_last marking the final character. Digits of the configured radix are
// accumulated, after an optional sign in signed mode, until a non-digit, the
// end of the string, or a digit that would break the configured limits.
// The rsp channel carries one transaction per string, on its last character:
// the value (two's complement in signed mode) and the count of characters
// consumed, saturating.
// A character is first registered in the input register, and the result of a
// last character is then registered in the result register behind rsp_valid.
// Throughput: one character per cycle except while a stalled result holds a last
// character; each digit step is a shift-add and one 69-bit compare to the limit.
// Reset clears the parse state and the pipeline and loads the default
// configuration. When the receiver stalls, the result register holds; a further
// last character waits in the input register and req_ready falls. The csr port
// writes one register per cycle; the user must use it while idle (not enforced).
module bounded_integer_text_parser
   import bitp_pkg::*;
#(
   parameter longint unsigned COUNT_MAX = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic [15:0] rsp_consumed,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int CW = $clog2(COUNT_MAX + 64'd1);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(COUNT_MAX);

   // Configuration registers.
   logic [1:0]  radix_ff;
   logic        signed_ff;
   logic [63:0] upper_ff;
   logic [63:0] lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_DEC;
         signed_ff <= 1'b1;
         upper_ff  <= INT64_MAX_VALUE;
         lower_ff  <= 64'h8000_0000_0000_0000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIX_MODE:  radix_ff  <= csr_wdata[1:0];
            CSR_SIGNED_MODE: signed_ff <= csr_wdata[0];
            CSR_UPPER_LIMIT: upper_ff  <= csr_wdata;
            CSR_LOWER_LIMIT: lower_ff  <= csr_wdata;
            default:         radix_ff  <= radix_ff;
         endcase
      end
   end

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       out_free;
   logic       proc_go;

   // A last character needs room in the result register; others always advance.
   assign out_free  = !rsp_valid || rsp_ready;
   assign proc_go   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || proc_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
   end

   // Parse state.
   logic [63:0]   acc_ff,   acc_in;
   logic [CW-1:0] cnt_ff,   cnt_in;
   phase_type     phase_ff, phase_in;
   logic          neg_ff,   neg_in;

   digit_type     dig;
   logic [63:0]   lim;
   logic [68:0]   prod;
   logic [68:0]   next_acc;
   logic          sign_taken;
   logic          in_digits;
   logic [CW-1:0] cnt_inc;
   logic [63:0]   value_out;
   logic [15:0]   consumed_out;

   assign dig = digit_decode(in_ch_ff, radix_ff);

   // Magnitude limit for the current sign and mode.
   always_comb begin
      if (!signed_ff) begin
         lim = upper_ff;
      end else if (neg_ff) begin
         lim = lower_ff[63] ? (64'd0 - lower_ff) : 64'd0;
      end else begin
         lim = (upper_ff > INT64_MAX_VALUE) ? INT64_MAX_VALUE : upper_ff;
      end
   end

   // Accumulator times radix by shifts, then the digit added in full width.
   always_comb begin
      unique case (radix_ff)
         RADIX_HEX: prod = {5'd0, acc_ff} << 4;
         RADIX_OCT: prod = {5'd0, acc_ff} << 3;
         default:   prod = ({5'd0, acc_ff} << 3) + ({5'd0, acc_ff} << 1);
      endcase
   end

   assign next_acc = prod + {65'd0, dig.val};
   assign cnt_inc  = (cnt_ff < COUNT_LIMIT) ? cnt_ff + CW'(1) : cnt_ff;

   assign sign_taken = (phase_ff == PH_START) && signed_ff &&
                       ((in_ch_ff == CHAR_MINUS) || (in_ch_ff == CHAR_PLUS));
   assign in_digits  = ((phase_ff == PH_START) && !sign_taken) || (phase_ff == PH_DIGITS);

   // One character step, then the result and a fresh start on the last character.
   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      if (sign_taken) begin
         phase_in = PH_DIGITS;
         neg_in   = (in_ch_ff == CHAR_MINUS);
         cnt_in   = cnt_inc;
      end else if (in_digits) begin
         if (!dig.ok || (next_acc > {5'd0, lim})) begin
            phase_in = PH_STOPPED;
         end else begin
            phase_in = PH_DIGITS;
            acc_in   = next_acc[63:0];
            cnt_in   = cnt_inc;
         end
      end
      value_out    = neg_in ? (64'd0 - acc_in) : acc_in;
      consumed_out = (64'(cnt_in) > 64'(CONSUMED_MAX)) ? CONSUMED_MAX : 16'(cnt_in);
      if (in_last_ff) begin
         acc_in   = 64'd0;
         cnt_in   = '0;
         phase_in = PH_START;
         neg_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 64'd0;
         cnt_ff   <= '0;
         phase_ff <= PH_START;
         neg_ff   <= 1'b0;
      end else if (proc_go) begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
      end
   end

   // Result register.
   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic [15:0] rsp_consumed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_go && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && in_last_ff) begin
         rsp_value_ff    <= value_out;
         rsp_consumed_ff <= consumed_out;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_consumed = rsp_consumed_ff;

`ifndef SYNTHESIS
   // The state starts over after the last character of a string.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (proc_go && in_last_ff) |=>
         (acc_ff == 64'd0) && (cnt_ff == '0) && (phase_ff == PH_START) && !neg_ff)
      else $error("parse state not cleared after the last character");

   // The character count never passes its saturation value.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_LIMIT)
      else $error("character count above its maximum");

   // A stopped parse leaves the accumulator alone until the string ends.
   a_stopped_hold: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_STOPPED) && !(proc_go && in_last_ff)) |=> (acc_ff == $past(acc_ff)))
      else $error("accumulator changed after the parse stopped");

   // A last character is never processed while a result is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(proc_go && in_last_ff))
      else $error("result overwritten while stalled");
`endif

endmodule
